// ===== design/tpaf_pkg.sv =====
// shared types, constants and helpers of the triac phase-angle firing core
`timescale 1ns / 1ps
`default_nettype none

package tpaf_pkg;

    // default parameter values
    localparam int TIME_BITS_DEF = 32;
    localparam int GOOD_MAX_DEF  = 15;

    // register file geometry
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    // register widths
    localparam int POWER_W    = 7;
    localparam int BIAS_W     = 7;
    localparam int HALF_W     = 14;
    localparam int PULSE_W    = 13;
    localparam int TOL_W      = 6;
    localparam int BOUND_W    = 16;
    localparam int DELAY_W    = 14;
    localparam int INTERVAL_W = 16;
    localparam int GOOD_OUT_W = 4;
    localparam int GOOD_CAP   = 15;

    // stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // register reset values
    localparam logic [POWER_W-1:0] POWER_RST = 7'd0;
    localparam logic [BIAS_W-1:0]  BIAS_RST  = 7'd17;
    localparam logic [HALF_W-1:0]  HALF_RST  = 14'd8333;
    localparam logic [PULSE_W-1:0] PULSE_RST = 13'd600;
    localparam logic [TOL_W-1:0]   TOL_RST   = 6'd8;
    localparam logic [BOUND_W-1:0] MIN_RST   = 16'd2000;
    localparam logic [BOUND_W-1:0] MAX_RST   = 16'd15000;

    // power thresholds and delay limits
    localparam logic [POWER_W-1:0] POWER_OFF_MAX  = 7'd1;
    localparam logic [POWER_W-1:0] POWER_FULL_MIN = 7'd99;
    localparam logic [POWER_W-1:0] PERCENT_FULL   = 7'd100;
    localparam logic signed [15:0] DELAY_MIN      = 16'sd100;
    localparam logic signed [15:0] DELAY_MARGIN   = 16'sd200;

    // floor(x / 100) for x below 2^21 as (x * K) >> 28
    localparam int          DIV_IN_W  = 21;
    localparam int          DIV_OUT_W = 15;
    localparam int          DIV_SHIFT = 28;
    localparam logic [21:0] DIV100_K  = 22'd2684355;

    // register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POWER  = 3'd0,
        CFG_BIAS   = 3'd1,
        CFG_HALF   = 3'd2,
        CFG_PULSE  = 3'd3,
        CFG_TOL    = 3'd4,
        CFG_MIN    = 3'd5,
        CFG_MAX    = 3'd6
    } t_cfg_reg;

    // settings prepared for the firing stage
    typedef struct packed {
        logic                   pwr_off;
        logic                   pwr_full;
        logic                   dly_cancel;
        logic [DELAY_W-1:0]     dly;
        logic [DIV_OUT_W-1:0]   tol_lo;
        logic [DIV_OUT_W-1:0]   tol_hi;
        logic [BOUND_W-1:0]     min_iv;
        logic [BOUND_W-1:0]     max_iv;
        logic [PULSE_W-1:0]     pulse_len;
    } t_fire_cfg;

    function automatic logic [DIV_OUT_W-1:0] div100(input logic [DIV_IN_W-1:0] x);
        logic [42:0] p;
        p = 43'(x) * 43'(DIV100_K);
        return DIV_OUT_W'(p >> DIV_SHIFT);
    endfunction

endpackage

`default_nettype wire

// ===== design/triac_phase_angle_firing_core.sv =====
// top level of the triac phase-angle firing core
// Usage: each input beat on s_axis is one microsecond tick; tdata bit 0 says a
// detector edge arrived this tick and bit 1 gives its level. Every input beat
// yields exactly one output beat on m_axis carrying the gate drive, the
// zero-cross flag, the last interval with its bounds check, the good-run
// count and the pending-fire flag.
// From the accepting edge to the output beat a beat passes an input register,
// the edge pairing and timestamp stage, then the interval and firing stage
// whose state registers drive m_axis. One beat is taken every cycle while
// m_axis_tready is high. Each stage holds its beat only until the next stage can
// take it, so input beats keep flowing into empty stages while a result waits on
// a stalled m_axis; once all three stages are full s_axis_tready drops.
// The user must write registers through i_cfg_we / i_cfg_addr / i_cfg_wdata only
// while no beat is in flight; the block does not enforce this. Derived tolerance
// window and firing delay settle via the product and settings registers before a
// following tick reaches the firing stage. Synchronous reset returns registers to
// defaults, clears timestamp, edge, run and pulse state and empties the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module triac_phase_angle_firing_core
    import tpaf_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int GOOD_MAX  = GOOD_MAX_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // edge_seen [0], edge_level [1], zero padding [7:2]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // gate_drive [0], zero_cross [1], interval_us [17:2], interval_ok [18],
    // good_count [22:19], fire_pending [23]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic                  r_v_in;
    logic                  r_v_s1;
    logic                  r_v_out;
    logic                  rdy_out;
    logic                  rdy_s1;
    logic                  accept;
    logic                  adv_s1;
    logic                  adv_out;

    t_fire_cfg             fire_cfg;
    logic                  zc;
    logic [TIME_BITS-1:0]  zt;
    logic                  gate_drive;
    logic                  zero_cross;
    logic [INTERVAL_W-1:0] interval_us;
    logic                  interval_ok;
    logic [GOOD_OUT_W-1:0] good_count;
    logic                  fire_pending;

    // stage handshake, each stage moves when the next is empty or moving
    assign rdy_out       = !r_v_out || m_axis_tready;
    assign adv_out       = r_v_s1 && rdy_out;
    assign rdy_s1        = !r_v_s1 || rdy_out;
    assign adv_s1        = r_v_in && rdy_s1;
    assign s_axis_tready = !r_v_in || rdy_s1;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_in  <= 1'b0;
            r_v_s1  <= 1'b0;
            r_v_out <= 1'b0;
        end else begin
            r_v_in  <= accept || (r_v_in && !adv_s1);
            r_v_s1  <= adv_s1 || (r_v_s1 && !adv_out);
            r_v_out <= adv_out || (r_v_out && !m_axis_tready);
        end
    end

    // register file
    tpaf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (fire_cfg)
    );

    // edge pairing stage
    tpaf_edge #(
        .TIME_BITS (TIME_BITS)
    ) u_edge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_edge_seen  (s_axis_tdata[0]),
        .i_edge_level (s_axis_tdata[1]),
        .i_advance    (adv_s1),
        .o_zc         (zc),
        .o_zt         (zt)
    );

    // firing stage
    tpaf_fire #(
        .TIME_BITS (TIME_BITS),
        .GOOD_MAX  (GOOD_MAX)
    ) u_fire (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (adv_out),
        .i_zc           (zc),
        .i_zt           (zt),
        .i_cfg          (fire_cfg),
        .o_gate_drive   (gate_drive),
        .o_zero_cross   (zero_cross),
        .o_interval_us  (interval_us),
        .o_interval_ok  (interval_ok),
        .o_good_count   (good_count),
        .o_fire_pending (fire_pending)
    );

    // output beat
    assign m_axis_tvalid = r_v_out;
    assign m_axis_tdata  = {fire_pending, good_count, interval_ok, interval_us,
                            zero_cross, gate_drive};

endmodule

`default_nettype wire

// ===== design/tpaf_cfg.sv =====
// register file and precomputed firing settings
`timescale 1ns / 1ps
`default_nettype none

module tpaf_cfg
    import tpaf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_fire_cfg                  o_cfg
);

    logic [POWER_W-1:0] r_power;
    logic [BIAS_W-1:0]  r_bias;
    logic [HALF_W-1:0]  r_half;
    logic [PULSE_W-1:0] r_pulse;
    logic [TOL_W-1:0]   r_tol;
    logic [BOUND_W-1:0] r_min;
    logic [BOUND_W-1:0] r_max;

    logic [19:0]          r_p_tol;
    logic [DIV_IN_W-1:0]  r_p_dly;
    logic [DIV_IN_W-1:0]  r_p_bias;
    logic [DIV_OUT_W-1:0] tol;
    logic [DIV_OUT_W-1:0] dly_a;
    logic [DIV_OUT_W-1:0] dly_b;
    logic signed [15:0]   dly_raw;
    logic signed [15:0]   dly_clamp;
    logic signed [15:0]   dly_lim;
    logic [DIV_OUT_W-1:0] half_x;
    t_fire_cfg            n_cfg;
    t_fire_cfg            r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_power <= POWER_RST;
            r_bias  <= BIAS_RST;
            r_half  <= HALF_RST;
            r_pulse <= PULSE_RST;
            r_tol   <= TOL_RST;
            r_min   <= MIN_RST;
            r_max   <= MAX_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_POWER: r_power <= i_cfg_wdata[POWER_W-1:0];
                CFG_BIAS:  r_bias  <= i_cfg_wdata[BIAS_W-1:0];
                CFG_HALF:  r_half  <= i_cfg_wdata[HALF_W-1:0];
                CFG_PULSE: r_pulse <= i_cfg_wdata[PULSE_W-1:0];
                CFG_TOL:   r_tol   <= i_cfg_wdata[TOL_W-1:0];
                CFG_MIN:   r_min   <= i_cfg_wdata[BOUND_W-1:0];
                CFG_MAX:   r_max   <= i_cfg_wdata[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    // first step: percent products of the half period
    always_ff @(posedge i_clk) begin
        r_p_tol  <= 20'(r_half) * 20'(r_tol);
        r_p_dly  <= DIV_IN_W'(r_half) * DIV_IN_W'(POWER_W'(PERCENT_FULL - r_power));
        r_p_bias <= DIV_IN_W'(r_half) * DIV_IN_W'(r_bias);
    end

    // second step: scale by 1/100, tolerance window and delay
    always_comb begin
        tol       = div100(DIV_IN_W'(r_p_tol));
        dly_a     = div100(r_p_dly);
        dly_b     = div100(r_p_bias);
        half_x    = DIV_OUT_W'(r_half);
        dly_raw   = $signed({1'b0, dly_a}) - $signed({1'b0, dly_b});
        dly_clamp = (dly_raw < DELAY_MIN) ? DELAY_MIN : dly_raw;
        dly_lim   = $signed({2'b00, r_half}) - DELAY_MARGIN;

        n_cfg            = '0;
        n_cfg.pwr_off    = (r_power <= POWER_OFF_MAX);
        n_cfg.pwr_full   = (r_power >= POWER_FULL_MIN);
        n_cfg.dly_cancel = (dly_clamp > dly_lim);
        n_cfg.dly        = dly_clamp[DELAY_W-1:0];
        n_cfg.tol_lo     = (half_x > tol) ? (half_x - tol) : '0;
        n_cfg.tol_hi     = half_x + tol;
        n_cfg.min_iv     = r_min;
        n_cfg.max_iv     = r_max;
        n_cfg.pulse_len  = r_pulse;
    end

    always_ff @(posedge i_clk) begin
        r_cfg <= n_cfg;
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/tpaf_edge.sv =====
// input register, timestamp counter and detector edge pairing
`timescale 1ns / 1ps
`default_nettype none

module tpaf_edge
    import tpaf_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic                 i_edge_seen,
    input  wire logic                 i_edge_level,
    input  wire logic                 i_advance,
    output logic                      o_zc,
    output logic [TIME_BITS-1:0]      o_zt
);

    logic                 r_in_seen;
    logic                 r_in_lvl;
    logic [TIME_BITS-1:0] r_now;
    logic [TIME_BITS-1:0] r_edge_time;
    logic                 r_edge_lvl;
    logic                 r_edge_held;
    logic                 r_zc;
    logic [TIME_BITS-1:0] r_zt;

    logic [TIME_BITS-1:0] n_edge_time;
    logic                 n_edge_lvl;
    logic                 n_edge_held;
    logic                 n_zc;
    logic [TIME_BITS-1:0] span;
    logic [TIME_BITS-1:0] n_zt;

    // input register
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in_seen <= i_edge_seen;
            r_in_lvl  <= i_edge_level;
        end
    end

    // pair opposite edges, midpoint is the zero crossing
    always_comb begin
        n_edge_time = r_edge_time;
        n_edge_lvl  = r_edge_lvl;
        n_edge_held = r_edge_held;
        n_zc        = 1'b0;
        span        = r_now - r_edge_time;
        n_zt        = r_edge_time + (span >> 1);
        if (r_in_seen) begin
            if (!r_edge_held) begin
                n_edge_time = r_now;
                n_edge_lvl  = r_in_lvl;
                n_edge_held = 1'b1;
            end else if (r_in_lvl == r_edge_lvl) begin
                n_edge_time = r_now;
            end else begin
                n_edge_held = 1'b0;
                n_edge_lvl  = 1'b0;
                n_zc        = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now       <= '0;
            r_edge_time <= '0;
            r_edge_lvl  <= 1'b0;
            r_edge_held <= 1'b0;
            r_zc        <= 1'b0;
        end else if (i_advance) begin
            r_now       <= r_now + 1'b1;
            r_edge_time <= n_edge_time;
            r_edge_lvl  <= n_edge_lvl;
            r_edge_held <= n_edge_held;
            r_zc        <= n_zc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_zt <= n_zt;
        end
    end

    assign o_zc = r_zc;
    assign o_zt = r_zt;

endmodule

`default_nettype wire

// ===== design/tpaf_fire.sv =====
// interval check, good-run count, delay countdown and gate pulse
`timescale 1ns / 1ps
`default_nettype none

module tpaf_fire
    import tpaf_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int GOOD_MAX  = GOOD_MAX_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_advance,
    input  wire logic                   i_zc,
    input  wire logic [TIME_BITS-1:0]   i_zt,
    input  wire t_fire_cfg              i_cfg,
    output logic                        o_gate_drive,
    output logic                        o_zero_cross,
    output logic [INTERVAL_W-1:0]       o_interval_us,
    output logic                        o_interval_ok,
    output logic [GOOD_OUT_W-1:0]       o_good_count,
    output logic                        o_fire_pending
);

    localparam int GOOD_W = $clog2(GOOD_MAX + 1);

    logic [TIME_BITS-1:0]  r_prev_zt;
    logic [GOOD_W-1:0]     r_good_run;
    logic [DELAY_W-1:0]    r_delay;
    logic                  r_armed;
    logic [PULSE_W-1:0]    r_pulse;
    logic [INTERVAL_W-1:0] r_interval;
    logic                  r_ok;
    logic                  r_zc;

    logic [TIME_BITS-1:0]  n_prev_zt;
    logic [GOOD_W-1:0]     n_good_run;
    logic [DELAY_W-1:0]    n_delay;
    logic                  n_armed;
    logic [PULSE_W-1:0]    n_pulse;
    logic [INTERVAL_W-1:0] n_interval;
    logic                  n_ok;
    logic [TIME_BITS-1:0]  diff;
    logic                  in_bounds;
    logic                  in_tol;

    // per-tick countdowns, then the zero-crossing update
    always_comb begin
        n_prev_zt  = r_prev_zt;
        n_good_run = r_good_run;
        n_delay    = r_delay;
        n_armed    = r_armed;
        n_pulse    = r_pulse;
        n_interval = r_interval;
        n_ok       = r_ok;
        diff       = i_zt - r_prev_zt;
        in_bounds  = (diff >= TIME_BITS'(i_cfg.min_iv)) && (diff <= TIME_BITS'(i_cfg.max_iv));
        in_tol     = (diff >= TIME_BITS'(i_cfg.tol_lo)) && (diff <= TIME_BITS'(i_cfg.tol_hi));

        if (r_pulse != '0) begin
            n_pulse = r_pulse - 1'b1;
        end
        if (r_armed) begin
            if (r_delay != '0) begin
                n_delay = r_delay - 1'b1;
            end
            if (n_delay == '0) begin
                n_armed = 1'b0;
                n_pulse = i_cfg.pulse_len;
            end
        end

        if (i_zc) begin
            n_prev_zt  = i_zt;
            n_interval = (|diff[TIME_BITS-1:INTERVAL_W]) ? '1 : diff[INTERVAL_W-1:0];
            n_ok       = in_bounds;
            if (in_bounds) begin
                if (!in_tol) begin
                    n_good_run = '0;
                end else if (32'(r_good_run) < GOOD_MAX) begin
                    n_good_run = r_good_run + 1'b1;
                end
                if (i_cfg.pwr_off) begin
                    n_armed = 1'b0;
                end else if (i_cfg.pwr_full) begin
                    n_armed = 1'b0;
                    n_pulse = i_cfg.pulse_len;
                end else if (i_cfg.dly_cancel) begin
                    n_armed = 1'b0;
                end else begin
                    n_delay = i_cfg.dly;
                    n_armed = 1'b1;
                end
            end
        end
    end

    // state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_zt  <= '0;
            r_good_run <= '0;
            r_delay    <= '0;
            r_armed    <= 1'b0;
            r_pulse    <= '0;
            r_interval <= '0;
            r_ok       <= 1'b0;
            r_zc       <= 1'b0;
        end else if (i_advance) begin
            r_prev_zt  <= n_prev_zt;
            r_good_run <= n_good_run;
            r_delay    <= n_delay;
            r_armed    <= n_armed;
            r_pulse    <= n_pulse;
            r_interval <= n_interval;
            r_ok       <= n_ok;
            r_zc       <= i_zc;
        end
    end

    assign o_gate_drive   = (r_pulse != '0);
    assign o_zero_cross   = r_zc;
    assign o_interval_us  = r_interval;
    assign o_interval_ok  = r_ok;
    assign o_good_count   = (32'(r_good_run) > GOOD_CAP) ? GOOD_OUT_W'(GOOD_CAP)
                                                         : GOOD_OUT_W'(r_good_run);
    assign o_fire_pending = r_armed;

endmodule

`default_nettype wire
